[design/egcd_pkg.sv]
// shared types and constants for the extended gcd core
`default_nettype none
package egcd_pkg;
  localparam int unsigned Width = 32;
  localparam int unsigned OpW   = Width - 1;
  localparam int unsigned CntW  = $clog2(OpW + 1);
  localparam int unsigned QDepth = 2;

  typedef struct packed {
    logic [OpW-1:0] value_a;
    logic [OpW-1:0] value_b;
    logic           b_zero;
  } job_t;
endpackage
`default_nettype wire

[design/egcd_front.sv]
// request intake, zero classification and a small job queue
`default_nettype none
module egcd_front (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [egcd_pkg::OpW-1:0] value_a_i,
  input  logic [egcd_pkg::OpW-1:0] value_b_i,
  output logic                    busy_o,
  output logic                    job_valid_o,
  input  logic                    job_take_i,
  output egcd_pkg::job_t          job_o
);
  import egcd_pkg::*;

  job_t       q_mem_q [QDepth];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       push;

  assign busy_o      = (cnt_q == 2'(QDepth));
  assign push        = start_i && !busy_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= '{value_a: value_a_i, value_b: value_b_i,
                         b_zero: (value_b_i == '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (job_take_i && job_valid_o) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_take_i && job_valid_o);
    end
  end
endmodule
`default_nettype wire

[design/egcd_back.sv]
// euclid loop with a bit-serial divider, continuant updates and inverse fixup
`default_nettype none
module egcd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     job_valid_i,
  output logic                     job_take_o,
  input  egcd_pkg::job_t           job_i,
  output logic                     done_o,
  output logic [egcd_pkg::OpW-1:0] gcd_value_o,
  output logic [egcd_pkg::Width-1:0] coef_x_o,
  output logic [egcd_pkg::Width-1:0] coef_y_o,
  output logic [egcd_pkg::OpW-1:0] inverse_o,
  output logic                     has_inverse_o
);
  import egcd_pkg::*;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StDiv  = 3'd1;
  localparam logic [2:0] StMul  = 3'd2;
  localparam logic [2:0] StRed  = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;

  logic [2:0]       st_q, st_d;
  logic [OpW-1:0]   a_q, b_q, mod_q, quo_q, rem_q;
  logic [CntW-1:0]  bit_q;
  logic [Width-1:0] pc_q, pp_q, sc_q, sp_q;
  logic             odd_q;
  logic [OpW:0]     trial;
  logic [OpW:0]     rsh;
  logic [Width-1:0] pc_n, sc_n;
  logic [Width-1:0] xv, yv;

  assign rsh   = {rem_q, a_q[OpW-1]};
  assign trial = rsh - {1'b0, b_q};
  // quotient times continuant, truncated to coefficient width
  assign pc_n = Width'({1'b0, quo_q} * pc_q) + pp_q;
  assign sc_n = Width'({1'b0, quo_q} * sc_q) + sp_q;
  assign xv = odd_q ? (Width'(0) - sp_q) : sp_q;
  assign yv = odd_q ? pp_q : (Width'(0) - pp_q);

  assign job_take_o = (st_q == StIdle) && job_valid_i;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (job_valid_i) st_d = job_i.b_zero ? StRed : StDiv;
      StDiv:  if (bit_q == CntW'(1)) st_d = StMul;
      StMul:  st_d = (rem_q == '0) ? StRed : StDiv;
      StRed:  if (!(a_q == OpW'(1) && mod_q != '0) || (sp_q < {1'b0, mod_q})) st_d = StOut;
      StOut:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= StIdle;
    else         st_q <= st_d;
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      StIdle: begin
        a_q <= job_i.value_a; b_q <= job_i.value_b; mod_q <= job_i.value_b;
        rem_q <= '0; quo_q <= '0; bit_q <= CntW'(OpW);
        pc_q <= Width'(1); pp_q <= '0; sc_q <= '0; sp_q <= Width'(1);
        odd_q <= 1'b0;
      end
      StDiv: begin
        // restoring division, one quotient bit per cycle, dividend shifts out of a_q
        a_q   <= {a_q[OpW-2:0], 1'b0};
        bit_q <= bit_q - CntW'(1);
        if (!trial[OpW]) begin
          rem_q <= trial[OpW-1:0];
          quo_q <= {quo_q[OpW-2:0], 1'b1};
        end else begin
          rem_q <= rsh[OpW-1:0];
          quo_q <= {quo_q[OpW-2:0], 1'b0};
        end
      end
      StMul: begin
        a_q <= b_q; b_q <= rem_q;
        pp_q <= pc_q; sp_q <= sc_q; pc_q <= pc_n; sc_q <= sc_n;
        odd_q <= ~odd_q; rem_q <= '0; quo_q <= '0; bit_q <= CntW'(OpW);
      end
      StRed: begin
        // s_prev mod modulus by repeated subtraction while s_prev is at least the modulus
        if (a_q == OpW'(1) && mod_q != '0 && sp_q >= {1'b0, mod_q})
          sp_q <= sp_q - {1'b0, mod_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StOut) begin
      gcd_value_o <= a_q;
      coef_x_o    <= xv;
      coef_y_o    <= yv;
      has_inverse_o <= (a_q == OpW'(1)) && (mod_q != '0);
      if ((a_q == OpW'(1)) && (mod_q != '0))
        inverse_o <= (odd_q && sp_q != '0) ? (mod_q - sp_q[OpW-1:0]) : sp_q[OpW-1:0];
      else
        inverse_o <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) done_o <= 1'b0;
    else         done_o <= (st_q == StOut);
  end
endmodule
`default_nettype wire

[design/extended_gcd_mod_inverse_core.sv]
// top level of the extended gcd and modular inverse core
// channel   | handshake           | payload
// request   | start_i / busy_o    | value_a_i, value_b_i
// result    | done_o (one cycle)  | gcd_value_o, coef_x_o, coef_y_o, inverse_o, has_inverse_o
// each euclid step runs the bit-serial divider over all dividend bits and then one continuant update,
// so the time a request takes grows with its number of euclid steps
// a two-entry queue takes requests while the back end works; busy_o rises when full
// the result is registered and shown for one cycle; the receiver cannot stall
// reset clears the queue and the sequencer; payload registers are not reset
`default_nettype none
module extended_gcd_mod_inverse_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [egcd_pkg::OpW-1:0]   value_a_i,
  input  logic [egcd_pkg::OpW-1:0]   value_b_i,
  output logic                       done_o,
  output logic [egcd_pkg::OpW-1:0]   gcd_value_o,
  output logic signed [egcd_pkg::Width-1:0] coef_x_o,
  output logic signed [egcd_pkg::Width-1:0] coef_y_o,
  output logic [egcd_pkg::OpW-1:0]   inverse_o,
  output logic                       has_inverse_o
);
  import egcd_pkg::*;

  job_t             job;
  logic             job_valid, job_take;
  logic [Width-1:0] cx, cy;

  // front end: accepts requests into the job queue
  egcd_front u_front (
    .clk_i, .rst_ni, .start_i, .value_a_i, .value_b_i, .busy_o,
    .job_valid_o(job_valid), .job_take_i(job_take), .job_o(job)
  );

  // back end: runs euclid and produces one result per job
  egcd_back u_back (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_take_o(job_take), .job_i(job),
    .done_o, .gcd_value_o, .coef_x_o(cx), .coef_y_o(cy), .inverse_o, .has_inverse_o
  );

  assign coef_x_o = cx;
  assign coef_y_o = cy;
endmodule
`default_nettype wire

[design/egcd_checker.sv]
// port-level checks for the extended gcd core and its bind
`default_nettype none
module egcd_checker (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic                     done_o,
  input logic [egcd_pkg::OpW-1:0] gcd_value_o,
  input logic [egcd_pkg::OpW-1:0] inverse_o,
  input logic                     has_inverse_o
);
  import egcd_pkg::*;

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held two cycles");
  a_inv_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && has_inverse_o) |-> (gcd_value_o == OpW'(1))) else $error("flag without unit gcd");
  a_inv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !has_inverse_o) |-> (inverse_o == '0)) else $error("inverse not zero");
  a_ctl_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$isunknown({start_i, busy_o, done_o})) else $error("handshake unknown");
endmodule

bind extended_gcd_mod_inverse_core egcd_checker u_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .gcd_value_o, .inverse_o, .has_inverse_o
);
`default_nettype wire

[dv/tb_extended_gcd_mod_inverse_core.sv]
// testbench for the extended gcd and modular inverse core
`default_nettype none
module tb_extended_gcd_mod_inverse_core;
  timeunit 1ns;
  timeprecision 1ps;

  import egcd_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 3000;
  localparam int unsigned NumRandom = 400;

  // one expected outcome of a request
  typedef struct packed {
    logic [OpW-1:0]   gcd;
    logic [Width-1:0] cx;
    logic [Width-1:0] cy;
    logic [OpW-1:0]   inv;
    logic             has;
  } egcd_res_t;

  // directed row: operands, and a hand-typed answer where chk is set
  typedef struct packed {
    logic [OpW-1:0] a;
    logic [OpW-1:0] b;
    logic           chk;
    egcd_res_t      res;
  } dir_row_t;

  logic clk, rst_n;
  logic start, busy, done, has_inverse;
  logic [OpW-1:0] value_a, value_b, gcd_value, inverse;
  logic signed [Width-1:0] coef_x, coef_y;

  egcd_res_t pending_q[$];
  int unsigned errors = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct;

  extended_gcd_mod_inverse_core i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .start_i      (start),
    .busy_o       (busy),
    .value_a_i    (value_a),
    .value_b_i    (value_b),
    .done_o       (done),
    .gcd_value_o  (gcd_value),
    .coef_x_o     (coef_x),
    .coef_y_o     (coef_y),
    .inverse_o    (inverse),
    .has_inverse_o(has_inverse)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // euclid with continuant tracking, 64-bit work registers
  function automatic egcd_res_t egcd_predict(logic [OpW-1:0] a_in, logic [OpW-1:0] b_in);
    logic [63:0] a, b, q, r, pc, pp, sc, sp, opp, osp, xv, yv, rm;
    logic odd;
    egcd_res_t res;
    a = 64'(a_in);
    b = 64'(b_in);
    pc = 1; pp = 0; sc = 0; sp = 1;
    odd = 1'b0;
    while (b != 0) begin
      q = a / b;
      r = a % b;
      opp = pp;
      osp = sp;
      a = b;
      b = r;
      pp = pc;
      sp = sc;
      pc = q * pp + opp;
      sc = q * sp + osp;
      odd = ~odd;
    end
    // sign of the coefficients follows the step parity
    xv = odd ? 64'd0 - sp : sp;
    yv = odd ? pp : 64'd0 - pp;
    res.gcd = a[OpW-1:0];
    res.cx = xv[Width-1:0];
    res.cy = yv[Width-1:0];
    res.inv = '0;
    res.has = 1'b0;
    if (a == 1 && b_in != 0) begin
      // negative coefficient folds into [0, modulus), not its magnitude
      rm = sp % 64'(b_in);
      if (odd && rm != 0) rm = 64'(b_in) - rm;
      res.inv = rm[OpW-1:0];
      res.has = 1'b1;
    end
    return res;
  endfunction

  // one request; the predicted or typed answer is queued on acceptance
  // start stays high after acceptance until the next idle cycle or the caller drops it
  task automatic send_request(logic [OpW-1:0] a, logic [OpW-1:0] b, egcd_res_t res);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    value_a <= a;
    value_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_q.push_back(res);
  endtask

  // result checker, sampled at the edge that ends the strobe cycle
  always @(posedge clk) begin
    egcd_res_t exp_res;
    if (rst_n && done) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result gcd=%0d", $time, gcd_value);
        errors++;
      end else begin
        exp_res = pending_q.pop_front();
        if (gcd_value !== exp_res.gcd) begin
          $display("%0t: gcd exp %0d got %0d", $time, exp_res.gcd, gcd_value);
          errors++;
        end
        if (coef_x !== exp_res.cx) begin
          $display("%0t: coef_x exp %0d got %0d", $time, $signed(exp_res.cx), coef_x);
          errors++;
        end
        if (coef_y !== exp_res.cy) begin
          $display("%0t: coef_y exp %0d got %0d", $time, $signed(exp_res.cy), coef_y);
          errors++;
        end
        if (inverse !== exp_res.inv) begin
          $display("%0t: inverse exp %0d got %0d", $time, exp_res.inv, inverse);
          errors++;
        end
        if (has_inverse !== exp_res.has) begin
          $display("%0t: has_inverse exp %0b got %0b", $time, exp_res.has, has_inverse);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("** extended_gcd_mod_inverse_core: FAILED **");
      $finish;
    end
  end

  localparam logic [OpW-1:0] MaxOp = {OpW{1'b1}};

  // directed table; typed answers where they are obvious
  dir_row_t dir_tbl[] = '{
    '{31'd0,  31'd0,  1'b1, '{31'd0,  32'd1, 32'd0, 31'd0, 1'b0}},  // both zero
    '{MaxOp,  31'd0,  1'b1, '{MaxOp,  32'd1, 32'd0, 31'd0, 1'b0}},  // zero modulus
    '{31'd5,  31'd0,  1'b1, '{31'd5,  32'd1, 32'd0, 31'd0, 1'b0}},
    '{31'd0,  MaxOp,  1'b0, '0},
    '{31'd0,  31'd1,  1'b0, '0},
    '{31'd7,  31'd1,  1'b0, '0},                                     // modulus one
    '{MaxOp,  31'd1,  1'b0, '0},
    '{MaxOp,  MaxOp,  1'b0, '0},
    '{MaxOp,  MaxOp-31'd1, 1'b0, '0},
    '{31'd3,  31'd7,  1'b0, '0},                                     // negative coef
    '{31'd4,  31'd6,  1'b0, '0},                                     // no inverse
    '{31'd1,  31'd1,  1'b0, '0},
    '{31'd1134903170, 31'd1836311903, 1'b0, '0},                     // fibonacci, many steps
    '{31'd1836311903, 31'd1134903170, 1'b0, '0},
    '{31'h2aaaaaaa, 31'h55555555, 1'b0, '0},
    '{31'h55555555, 31'h2aaaaaaa, 1'b0, '0},
    '{31'd17, 31'd3120, 1'b0, '0},
    '{31'd1024, 31'd4096, 1'b0, '0}
  };

  function automatic logic [OpW-1:0] rand_operand();
    logic [OpW-1:0] v;
    case ($urandom_range(3))
      0: v = OpW'($urandom_range(1000));
      1: v = OpW'($urandom) >> $urandom_range(OpW - 1);
      default: v = OpW'($urandom);
    endcase
    return v;
  endfunction

  initial begin
    logic [OpW-1:0] ra, rb, g;
    send_idle_pct = 16;
    start <= 1'b0;
    value_a <= '0;
    value_b <= '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      send_request(dir_tbl[i].a, dir_tbl[i].b,
                   dir_tbl[i].chk ? dir_tbl[i].res : egcd_predict(dir_tbl[i].a, dir_tbl[i].b));
    end
    start <= 1'b0;

    // sender holds off until every pending result is back
    while (pending_q.size() != 0) @(posedge clk);

    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 3) send_idle_pct = 88;
      if (n == 2 * NumRandom / 3) send_idle_pct = 0;
      ra = rand_operand();
      rb = rand_operand();
      // sometimes share a factor so gcd differs from one
      if ($urandom_range(4) == 0) begin
        g = OpW'($urandom_range(2, 64));
        ra = OpW'((ra % 31'd30000000) * g);
        rb = OpW'((rb % 31'd30000000) * g);
      end
      send_request(ra, rb, egcd_predict(ra, rb));
    end
    start <= 1'b0;

    while (pending_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (errors == 0) begin
      $display("** extended_gcd_mod_inverse_core: PASSED **");
    end else begin
      $display("** extended_gcd_mod_inverse_core: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
design/egcd_pkg.sv
design/egcd_front.sv
design/egcd_back.sv
design/extended_gcd_mod_inverse_core.sv
design/egcd_checker.sv
dv/tb_extended_gcd_mod_inverse_core.sv
